[hw/rtl/cpos_pkg.sv]
`timescale 1ns / 1ps

package cpos_pkg;

  localparam int OSC_MAX   = 64;
  localparam int IDX_W     = 6;
  localparam int PH_W      = 24;
  localparam int SINE_DEPTH = 1024;
  localparam int SINE_IDX_W = 10;
  localparam int DVD_W     = 47;   // |radian sum| >> 16
  localparam int DVS_W     = 7;    // divisor: 1..64

  // round(2^32 / (2 pi)), turns per radian in Q32
  localparam logic [29:0] INV_TWO_PI = 30'd683565276;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  localparam logic [0:0] CMD_LOAD = 1'b0;
  localparam logic [0:0] CMD_STEP = 1'b1;

  localparam logic [1:0] MODE_ALL  = 2'd0;
  localparam logic [1:0] MODE_NBR  = 2'd1;
  localparam logic [1:0] MODE_DIFF = 2'd2;

  localparam logic [0:0] REG_NUM_OSC = 1'b0;

  typedef logic signed [31:0] sine_lut_t [SINE_DEPTH];

  // Q1.30 sine table from an integer Taylor series, evaluated at elaboration
  function automatic sine_lut_t build_sine();
    sine_lut_t lut;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] s;
    int q;
    for (int t = 0; t < SINE_DEPTH; t++) begin
      q = (t >> 8) & 3;
      r = 64'(t & 255) << 22;
      if ((q & 1) != 0) r = (64'd1 << 30) - r;
      x = (r * TWO_PI_Q30) >> 32;
      x2 = (x * x) >> 30;
      s = signed'(x);
      term = x;
      for (int k = 1; k <= 5; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if ((k & 1) != 0) s = s - signed'(term);
        else s = s + signed'(term);
      end
      if (s < 0) s = 0;
      if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
      lut[t] = 32'((q >= 2) ? -s : s);
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine();

endpackage

[hw/rtl/coupled_phase_oscillator_step_top.sv]
`timescale 1ns / 1ps

// Channel  Ports          Moves
// in       in_t*          load (tuser=0) or step (tuser=1) for one oscillator
// out      out_t*         new phase of one stepped oscillator, tlast on N-1
// cfg      cfg_p*         register 0 at byte 0: num_oscillators (7 bits)
//
// Before its result is registered, a step makes one phase read per term through the
// bank memory and sine ROM, a 47-bit bit-serial divide and two passes through the
// shared multiplier. The next transfer can be taken in the cycle after the result is
// registered. A load writes the bank memory as it is accepted. in_tready is high
// only while the sequencer is idle. The output register holds a result until taken;
// a second result waits in the last state and stalls the input.
// Reset is synchronous and clears the phase banks via valid bits.
module coupled_phase_oscillator_step_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [5:0] osc_index, [7:6] mode, [31:8] increment, [55:32] ext_phase,
  // [79:56] int_gain, [103:80] ext_gain
  input  logic [103:0] in_tdata,
  // [0] cmd
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [5:0] result_index, [29:6] phase_out, [31:30] zero
  output logic [31:0]  out_tdata,
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int IW = cpos_pkg::IDX_W;
  localparam int PW = cpos_pkg::PH_W;
  localparam int AW = IW + 1;
  localparam int SW = cpos_pkg::SINE_IDX_W;
  localparam int DW = cpos_pkg::DVD_W;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SELF  = 10'b0000000010,
    S_SELFW = 10'b0000000100,
    S_TERMS = 10'b0000001000,
    S_DRAIN = 10'b0000010000,
    S_DIVGO = 10'b0000100000,
    S_DIVW  = 10'b0001000000,
    S_MULHI = 10'b0010000000,
    S_MULLO = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [6:0] num_osc_r;
  logic [6:0] n_eff;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_osc_r <= 7'd2;
    end else if (cfg_wr && (cfg_paddr[2] == cpos_pkg::REG_NUM_OSC)) begin
      num_osc_r <= cfg_pwdata[6:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == cpos_pkg::REG_NUM_OSC) ? {25'd0, num_osc_r} : 32'd0;

  always_comb begin
    if (num_osc_r == 7'd0) n_eff = 7'd1;
    else if (num_osc_r > 7'(cpos_pkg::OSC_MAX)) n_eff = 7'(cpos_pkg::OSC_MAX);
    else n_eff = num_osc_r;
  end

  // input fields
  logic [IW-1:0]        f_idx;
  logic [1:0]           f_mode;
  logic                 in_xfer;

  assign f_idx = in_tdata[5:0];
  assign f_mode = (in_tdata[7:6] > cpos_pkg::MODE_DIFF) ? cpos_pkg::MODE_DIFF : in_tdata[7:6];
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer = in_tvalid & in_tready;

  logic [IW-1:0]        k_r;
  logic [1:0]           mode_r;
  logic [PW-1:0]        inc_r;
  logic [PW-1:0]        ext_r;
  logic signed [23:0]   ci_r;
  logic signed [23:0]   ce_r;
  logic                 bank_r;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      k_r    <= f_idx;
      mode_r <= f_mode;
      inc_r  <= in_tdata[31:8];
      ext_r  <= in_tdata[55:32];
      ci_r   <= signed'(in_tdata[79:56]);
      ce_r   <= signed'(in_tdata[103:80]);
    end
  end

  // ring neighbours
  logic [IW-1:0] n_last;
  logic [IW-1:0] right_idx;
  logic [IW-1:0] left_idx;
  logic          is_last;

  assign n_last = IW'(n_eff - 7'd1);
  assign right_idx = (k_r == n_last) ? '0 : IW'(k_r + 1'b1);
  assign left_idx = (k_r == '0) ? n_last : IW'(k_r - 1'b1);
  assign is_last = (k_r == n_last);

  // term sequencing
  logic [6:0]    cnt_r, cnt_nxt;
  logic [6:0]    n_mem;
  logic [IW-1:0] term_addr;

  assign n_mem = (mode_r == cpos_pkg::MODE_ALL) ? n_eff : 7'd2;

  always_comb begin
    if (mode_r == cpos_pkg::MODE_ALL) term_addr = cnt_r[IW-1:0];
    else if (cnt_r == 7'd0) term_addr = right_idx;
    else term_addr = left_idx;
  end

  // bank memory with valid bits, one port each way
  logic [PW-1:0]  mem [2**AW];
  logic [2**AW-1:0] vld_r;
  logic [PW-1:0]  mem_q_r;
  logic           vld_q_r;
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  wr_addr;
  logic [PW-1:0]  wr_data;
  logic           wr_en;
  logic [PW-1:0]  mem_phase;
  logic [PW-1:0]  new_phase;
  logic           fin_go;

  assign rd_addr = (state_r == S_SELF) ? {bank_r, k_r} : {bank_r, term_addr};
  assign fin_go = (state_r == S_FIN) && !(out_tvalid && !out_tready);

  always_comb begin
    wr_en = 1'b0;
    wr_addr = {bank_r, f_idx};
    wr_data = in_tdata[55:32];
    if (in_xfer && (in_tuser[0] == cpos_pkg::CMD_LOAD)) begin
      wr_en = 1'b1;
    end else if (fin_go) begin
      wr_en = 1'b1;
      wr_addr = {~bank_r, k_r};
      wr_data = new_phase;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    mem_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (wr_en) vld_r[wr_addr] <= 1'b1;
      vld_q_r <= vld_r[rd_addr];
    end
  end

  assign mem_phase = vld_q_r ? mem_q_r : '0;

  // term pipeline: read, sine ROM, multiply, accumulate
  logic [PW-1:0]       self_r;
  logic                t1_v_r, t1_ext_r, t1_neg_r;
  logic                t2_v_r, t2_ext_r, t2_neg_r;
  logic                t3_v_r, t3_neg_r;
  logic [PW-1:0]       to_phase;
  logic [PW-1:0]       diff;
  logic signed [31:0]  sine_q_r;
  logic signed [63:0]  acc_r;
  logic signed [63:0]  prod_r;
  logic signed [31:0]  mul_a;
  logic signed [31:0]  mul_b;
  logic signed [63:0]  mul_p;

  assign to_phase = t1_ext_r ? ext_r : mem_phase;
  assign diff = to_phase - self_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r <= 1'b0;
      t2_v_r <= 1'b0;
      t3_v_r <= 1'b0;
    end else begin
      t1_v_r <= (state_r == S_TERMS);
      t2_v_r <= t1_v_r;
      t3_v_r <= t2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    t1_ext_r <= (cnt_r == n_mem);
    t1_neg_r <= (mode_r == cpos_pkg::MODE_DIFF) && (cnt_r == 7'd1);
    t2_ext_r <= t1_ext_r;
    t2_neg_r <= t1_neg_r;
    t3_neg_r <= t2_neg_r;
    sine_q_r <= cpos_pkg::SINE_LUT[diff[PW-1 -: SW]];
    if (state_r == S_SELFW) self_r <= mem_phase;
  end

  // shared multiplier
  logic [DW-1:0]      quo;
  logic [54:0]        thi_r;

  always_comb begin
    unique case (state_r)
      S_MULHI: begin
        mul_a = signed'({7'd0, quo[DW-1:22]});
        mul_b = signed'({2'd0, cpos_pkg::INV_TWO_PI});
      end
      S_MULLO: begin
        mul_a = signed'({10'd0, quo[21:0]});
        mul_b = signed'({2'd0, cpos_pkg::INV_TWO_PI});
      end
      default: begin
        mul_a = sine_q_r;
        mul_b = t2_ext_r ? 32'(ce_r) : 32'(ci_r);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    // low product stays put while the result waits for the output register
    if (state_r != S_FIN) prod_r <= mul_p;
    if (state_r == S_MULLO) thi_r <= prod_r[54:0];
    if (state_r == S_SELFW) acc_r <= '0;
    else if (t3_v_r) acc_r <= t3_neg_r ? acc_r - prod_r : acc_r + prod_r;
  end

  // magnitude, divide by N or 2
  logic         neg_r;
  logic [63:0]  mag;
  logic         div_done;

  assign mag = acc_r[63] ? 64'(-acc_r) : 64'(acc_r);

  always_ff @(posedge clk) begin
    if (state_r == S_DIVGO) neg_r <= acc_r[63];
  end

  cpos_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_DIVGO),
    .dividend (mag[62:16]),
    .divisor  ((mode_r == cpos_pkg::MODE_ALL) ? n_eff : 7'd2),
    .done     (div_done),
    .quotient (quo)
  );

  // radians to turns, sign back, new phase
  logic [55:0]   tsum;
  logic [PW-1:0] tturn;

  assign tsum = {1'b0, thi_r} + 56'(prod_r[51:22]);
  assign tturn = neg_r ? PW'(-tsum[39:16]) : tsum[39:16];
  assign new_phase = self_r + inc_r + tturn;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_xfer && (in_tuser[0] == cpos_pkg::CMD_STEP) && ({1'b0, f_idx} < n_eff))
          state_nxt = S_SELF;
      end
      S_SELF:  state_nxt = S_SELFW;
      S_SELFW: state_nxt = S_TERMS;
      S_TERMS: begin
        if (cnt_r == n_mem) begin
          cnt_nxt = '0;
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DRAIN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 7'd2) state_nxt = S_DIVGO;
      end
      S_DIVGO: state_nxt = S_DIVW;
      S_DIVW:  if (div_done) state_nxt = S_MULHI;
      S_MULHI: state_nxt = S_MULLO;
      S_MULLO: state_nxt = S_FIN;
      S_FIN:   if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      bank_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (fin_go && is_last) bank_r <= ~bank_r;
    end
  end

  // output register
  logic          out_valid_r;
  logic [IW-1:0] out_idx_r;
  logic [PW-1:0] out_ph_r;
  logic          out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_idx_r  <= k_r;
      out_ph_r   <= new_phase;
      out_last_r <= is_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {2'b00, out_ph_r, out_idx_r};
  assign out_tlast = out_last_r;

endmodule

[hw/rtl/cpos_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module cpos_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [cpos_pkg::DVD_W-1:0]    dividend,
  input  logic [cpos_pkg::DVS_W-1:0]    divisor,
  output logic                          done,
  output logic [cpos_pkg::DVD_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(cpos_pkg::DVD_W);

  logic                         run_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [cpos_pkg::DVS_W-1:0]   rem_r;
  logic [cpos_pkg::DVS_W-1:0]   rem_nxt;
  logic [cpos_pkg::DVD_W-1:0]   quo_r;
  logic [cpos_pkg::DVS_W:0]     shifted;
  logic                         ge;
  logic                         done_r;

  // shift in next dividend bit and try a subtract
  always_comb begin
    shifted = {rem_r, quo_r[cpos_pkg::DVD_W-1]};
    ge = (shifted >= {1'b0, divisor});
    if (ge) rem_nxt = cpos_pkg::DVS_W'(shifted - {1'b0, divisor});
    else rem_nxt = shifted[cpos_pkg::DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(cpos_pkg::DVD_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[cpos_pkg::DVD_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quotient = quo_r;

endmodule

[verif/coupled_phase_oscillator_step_top_tb.sv]
`timescale 1ns / 1ps

module coupled_phase_oscillator_step_top_tb;

  localparam int WATCHDOG_LIMIT = 200000;

  // Expected result of one oscillator step
  typedef struct packed {
    logic [5:0]  idx;
    logic [23:0] phase;
    logic        last;
  } osc_result_t;

  // Bank model plus queue of expected results
  class osc_bank_scoreboard;
    logic [23:0]  bank_a [cpos_pkg::OSC_MAX];
    logic [23:0]  bank_b [cpos_pkg::OSC_MAX];
    logic         sel;
    logic [6:0]   num_osc;
    osc_result_t  pending_q[$];
    int           errors;

    function new();
      foreach (bank_a[i]) begin
        bank_a[i] = '0;
        bank_b[i] = '0;
      end
      sel = 1'b0;
      num_osc = 7'd2;
      errors = 0;
    endfunction

    function logic signed [63:0] sine_diff(logic [23:0] to_ph, logic [23:0] from_ph);
      logic [23:0] d;
      d = to_ph - from_ph;
      return 64'(cpos_pkg::SINE_LUT[d[23:14]]);
    endfunction

    function logic [23:0] rad_to_turns(logic signed [63:0] acc, logic [63:0] dv);
      logic [63:0] m;
      logic [63:0] t;
      m = acc[63] ? -acc : acc;
      m = (m / dv) >> 16;
      t = (m >> 22) * 64'(cpos_pkg::INV_TWO_PI)
          + (((m & 64'h3FFFFF) * 64'(cpos_pkg::INV_TWO_PI)) >> 22);
      t = t >> 16;
      return acc[63] ? 24'(-t) : t[23:0];
    endfunction

    function logic [23:0] rd(int k);
      return sel ? bank_b[k] : bank_a[k];
    endfunction

    // Note an accepted input transfer and queue any result it causes
    function void note_input(logic cmd, logic [103:0] d);
      logic [5:0] k;
      logic [1:0] md;
      logic [23:0] self_ph, ext, newp;
      logic signed [63:0] ci, ce, acc, sum;
      int n, lft, rgt;
      k = d[5:0];
      md = (d[7:6] > cpos_pkg::MODE_DIFF) ? cpos_pkg::MODE_DIFF : d[7:6];
      ext = d[55:32];
      ci = 64'(signed'(d[79:56]));
      ce = 64'(signed'(d[103:80]));
      n = (num_osc == 0) ? 1 : (num_osc > cpos_pkg::OSC_MAX) ? cpos_pkg::OSC_MAX : num_osc;
      if (cmd == cpos_pkg::CMD_LOAD) begin
        if (sel) bank_b[k] = ext;
        else bank_a[k] = ext;
        return;
      end
      if (k >= n) return;
      self_ph = rd(k);
      lft = (k + n - 1) % n;
      rgt = (k + 1) % n;
      if (md == cpos_pkg::MODE_ALL) begin
        sum = 0;
        for (int j = 0; j < n; j++) sum += sine_diff(rd(j), self_ph);
        acc = sum * ci;
      end else begin
        acc = sine_diff(rd(rgt), self_ph) * ci;
        if (md == cpos_pkg::MODE_NBR) acc += sine_diff(rd(lft), self_ph) * ci;
        else acc -= sine_diff(rd(lft), self_ph) * ci;
      end
      acc += sine_diff(ext, self_ph) * ce;
      newp = self_ph + d[31:8]
             + rad_to_turns(acc, (md == cpos_pkg::MODE_ALL) ? 64'(n) : 64'd2);
      if (sel) bank_a[k] = newp;
      else bank_b[k] = newp;
      pending_q.push_back('{idx: k, phase: newp, last: (k == n - 1)});
      if (k == n - 1) sel = ~sel;
    endfunction

    // Compare one output transfer with the oldest expectation
    function void check_result(logic [31:0] d, logic lst);
      osc_result_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result idx=%0d phase=%h", d[5:0], d[29:6]);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (d[5:0] !== e.idx) begin
        $error("result_index exp %0d got %0d", e.idx, d[5:0]);
        errors++;
      end
      if (d[29:6] !== e.phase) begin
        $error("phase_out exp %h got %h", e.phase, d[29:6]);
        errors++;
      end
      if (lst !== e.last) begin
        $error("last_of_sample exp %0d got %0d", e.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [103:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic out_tlast;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  osc_bank_scoreboard sb;
  int send_idle_pct = 13;
  int recv_idle_pct = 75;
  int hold_off = 0;
  int quiet_cycles = 0;

  always #10 clk = ~clk;

  coupled_phase_oscillator_step_top i_dut (.*);

  // Receiver: random stalls plus one long hold-off in one phase
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Output checking and watchdog
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("coupled_phase_oscillator_step_top regression: fail");
      $finish;
    end
  end

  // valid stays up between back-to-back transfers; idle cycles drop it
  task automatic send_item(logic cmd, logic [103:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(cmd, d);
  endtask

  task automatic pack_send(logic cmd, logic [5:0] k, logic [1:0] md, logic [23:0] inc,
                           logic [23:0] ph, logic [23:0] ci, logic [23:0] ce);
    send_item(cmd, {ce, ci, ph, inc, md, k});
  endtask

  task automatic write_num_osc(logic [31:0] v);
    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 3'(cpos_pkg::REG_NUM_OSC) << 2;
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sb.num_osc = v[6:0];
  endtask

  function automatic logic [23:0] rand_gain();
    case ($urandom_range(3))
      0: return 24'(signed'(17'($urandom_range(131071))) >>> 0) ;
      1: return 24'h800000;
      2: return 24'h7FFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  // One sample: optional loads, then steps over all oscillators, with some noise
  task automatic run_sample(int n, bit do_load);
    logic [1:0] md;
    md = 2'($urandom_range(3));
    if (do_load)
      for (int k = 0; k < n; k++)
        pack_send(cpos_pkg::CMD_LOAD, 6'(k), 2'($urandom), 24'($urandom), 24'($urandom),
                  24'($urandom), 24'($urandom));
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(19) == 0)
        pack_send(1'($urandom), 6'($urandom), 2'($urandom), 24'($urandom), 24'($urandom),
                  rand_gain(), rand_gain());
      pack_send(cpos_pkg::CMD_STEP, 6'(k), md, 24'($urandom), 24'($urandom),
                rand_gain(), rand_gain());
    end
  endtask

  initial begin
    int n;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset N=2, extremes, every mode, ignored items
    pack_send(cpos_pkg::CMD_STEP, 6'd0, cpos_pkg::MODE_ALL, 24'h7FFFFF, 24'h000000,
              24'h7FFFFF, 24'h800000);
    pack_send(cpos_pkg::CMD_STEP, 6'd1, cpos_pkg::MODE_NBR, 24'h800000, 24'hFFFFFF,
              24'h800000, 24'h7FFFFF);
    pack_send(cpos_pkg::CMD_LOAD, 6'd0, cpos_pkg::MODE_ALL, 24'h0, 24'h400000, 24'h0, 24'h0);
    pack_send(cpos_pkg::CMD_LOAD, 6'd1, cpos_pkg::MODE_ALL, 24'h0, 24'hC00000, 24'h0, 24'h0);
    pack_send(cpos_pkg::CMD_LOAD, 6'd63, cpos_pkg::MODE_ALL, 24'h0, 24'hFFFFFF, 24'h0, 24'h0);
    pack_send(cpos_pkg::CMD_STEP, 6'd5, cpos_pkg::MODE_ALL, 24'h1, 24'h1, 24'h1, 24'h1);
    pack_send(cpos_pkg::CMD_STEP, 6'd0, cpos_pkg::MODE_DIFF, 24'h0, 24'h123456,
              24'h7FFFFF, 24'h7FFFFF);
    pack_send(cpos_pkg::CMD_STEP, 6'd1, 2'd3, 24'hFFFFFF, 24'hABCDEF, 24'h800000, 24'h800000);
    pack_send(cpos_pkg::CMD_STEP, 6'd1, cpos_pkg::MODE_ALL, 24'h0, 24'h0, 24'h010000, 24'h0);
    write_num_osc(32'd1);
    pack_send(cpos_pkg::CMD_STEP, 6'd0, cpos_pkg::MODE_NBR, 24'h100, 24'h800000,
              24'h7FFFFF, 24'h7FFFFF);
    pack_send(cpos_pkg::CMD_STEP, 6'd0, cpos_pkg::MODE_ALL, 24'h100, 24'h200000,
              24'h7FFFFF, 24'h800000);
    write_num_osc(32'd0);
    pack_send(cpos_pkg::CMD_STEP, 6'd0, cpos_pkg::MODE_DIFF, 24'h0, 24'h0, 24'h0, 24'h7FFFFF);
    write_num_osc(32'd127);
    pack_send(cpos_pkg::CMD_STEP, 6'd63, cpos_pkg::MODE_ALL, 24'h0, 24'h0,
              24'h7FFFFF, 24'h7FFFFF);

    // Random samples across several sizes and idle profiles
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: n = 3;
        1: n = 64;
        2: n = 1;
        3: n = 5;
        4: n = 2;
        default: n = 7;
      endcase
      if (ph == 2) begin
        send_idle_pct = 75;
        recv_idle_pct = 13;
      end
      if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_num_osc(n);
      if (ph == 3) hold_off = 3000;
      for (int s = 0; s < ((n == 64) ? 2 : 130 / (n + 1) + 6); s++) begin
        run_sample(n, (s % 4) == 0);
      end
    end

    // Drain and settle
    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("coupled_phase_oscillator_step_top regression: pass");
    end else begin
      $display("coupled_phase_oscillator_step_top regression: fail");
    end
    $finish;
  end

endmodule
